>>> rtl/core/deq_pkg.sv
// Package for the double-ended queue core: command and result transaction
// types, command codes and status codes. No dependencies.
`default_nettype none

package deq_pkg;

    // Command codes carried in the func field.
    localparam logic [2:0] FUNC_NONE       = 3'd0;
    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd2;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd3;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd4;

    // Status codes returned with each result.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_POP_EMPTY = 2'd1;
    localparam logic [1:0] STAT_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] push_value;
    } t_deq_cmd;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [10:0]        element_count;
        logic               is_empty;
        logic [1:0]         status;
    } t_deq_result;

endpackage

`default_nettype wire

>>> rtl/core/deq_ram.sv
// Simple dual-port RAM for the queue store: one write port, one read port
// with registered read data. No dependencies.
`default_nettype none

module deq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/core/double_ended_queue_core.sv
// Double-ended queue core: a ring buffer in deq_ram with cached front and
// back words. Depends on deq_pkg and deq_ram.
//
//   Channel   Direction  Ports                 Handshake
//   command   in         i_cmd                 start high while busy low
//   result    out        o_result              o_valid for one cycle
//
// Pushes, no-ops, unknown codes, a pop on an empty queue and a pop that
// empties the queue need no fetch: the result appears the cycle after the
// command is taken and busy stays low.
// A pop that leaves words behind must fetch the new front or back word from
// the RAM, whose read data is registered; busy is high in the fetch state,
// and the result follows it. The receiver cannot stall the result.
// Synchronous active-low reset empties the queue; the RAM is not cleared.
`default_nettype none

module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_deq_cmd    i_cmd,
    output logic             o_valid,
    output t_deq_result      o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } t_state;

    typedef logic [AW-1:0]         t_idx;
    typedef logic [DATA_WIDTH-1:0] t_word;

    function automatic t_idx wrap_inc(input t_idx i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    function automatic t_idx wrap_dec(input t_idx i);
        return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
    endfunction

    // Stored words leave zero-extended or truncated to 32 bits.
    function automatic logic [31:0] word_out(input t_word w);
        logic [63:0] w64;
        w64 = 64'(w);
        return w64[31:0];
    endfunction

    t_state        r_state,  n_state;
    t_idx          r_head,   n_head;
    t_idx          r_tail,   n_tail;
    logic [CW-1:0] r_count,  n_count;
    t_word         r_front,  n_front;
    t_word         r_back,   n_back;
    t_word         r_popped, n_popped;
    logic [1:0]    r_status, n_status;
    logic          r_fetch_front, n_fetch_front;
    logic          r_valid;
    t_deq_result   r_result, n_result;
    logic          n_emit;

    logic          wr_en;
    t_idx          wr_addr;
    logic          rd_en;
    t_idx          rd_addr;
    t_word         rd_data;
    t_word         push_word;
    logic [63:0]   push_ext;
    logic [63:0]   count_ext;
    logic          is_full;
    logic          is_empty_now;

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (push_word),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign push_ext     = {{32{i_cmd.push_value[31]}}, i_cmd.push_value};
    assign push_word    = push_ext[DATA_WIDTH-1:0];
    assign is_full      = (r_count == CW'(DEPTH));
    assign is_empty_now = (r_count == '0);
    assign busy         = (r_state == ST_FETCH);

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_front       = r_front;
        n_back        = r_back;
        n_popped      = r_popped;
        n_status      = r_status;
        n_fetch_front = r_fetch_front;
        n_emit        = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = r_tail;
        rd_en         = 1'b0;
        rd_addr       = r_head;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_popped = '1;
                    n_status = STAT_OK;
                    n_emit   = 1'b1;
                    case (i_cmd.func)
                        FUNC_NONE: begin
                        end
                        FUNC_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = STAT_PUSH_FULL;
                            end else begin
                                n_head  = wrap_dec(r_head);
                                wr_en   = 1'b1;
                                wr_addr = n_head;
                                n_front = push_word;
                                if (is_empty_now) begin
                                    n_back = push_word;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        FUNC_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = STAT_PUSH_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_tail;
                                n_tail  = wrap_inc(r_tail);
                                n_back  = push_word;
                                if (is_empty_now) begin
                                    n_front = push_word;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        FUNC_POP_FRONT: begin
                            if (is_empty_now) begin
                                n_status = STAT_POP_EMPTY;
                            end else begin
                                n_popped = r_front;
                                n_head   = wrap_inc(r_head);
                                n_count  = r_count - CW'(1);
                                // Words remain, so the new front comes from the RAM.
                                if (r_count != CW'(1)) begin
                                    rd_en         = 1'b1;
                                    rd_addr       = n_head;
                                    n_fetch_front = 1'b1;
                                    n_state       = ST_FETCH;
                                    n_emit        = 1'b0;
                                end
                            end
                        end
                        FUNC_POP_BACK: begin
                            if (is_empty_now) begin
                                n_status = STAT_POP_EMPTY;
                            end else begin
                                n_popped = r_back;
                                n_tail   = wrap_dec(r_tail);
                                n_count  = r_count - CW'(1);
                                if (r_count != CW'(1)) begin
                                    rd_en         = 1'b1;
                                    rd_addr       = wrap_dec(n_tail);
                                    n_fetch_front = 1'b0;
                                    n_state       = ST_FETCH;
                                    n_emit        = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                n_state = ST_IDLE;
                n_emit  = 1'b1;
                if (r_fetch_front) begin
                    n_front = rd_data;
                end else begin
                    n_back = rd_data;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign count_ext = 64'(n_count);

    always_comb begin
        n_result.popped_value  = word_out(n_popped);
        n_result.front_value   = word_out((n_count == '0) ? '1 : n_front);
        n_result.back_value    = word_out((n_count == '0) ? '1 : n_back);
        n_result.element_count = count_ext[10:0];
        n_result.is_empty      = (n_count == '0);
        n_result.status        = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_valid <= n_emit;
        end
        r_front       <= n_front;
        r_back        <= n_back;
        r_popped      <= n_popped;
        r_status      <= n_status;
        r_fetch_front <= n_fetch_front;
        if (n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // The queue never holds more words than the ring has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("stored count exceeds depth");

    // An empty queue has coinciding head and tail.
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    // After the fetch state the core returns to idle in the next cycle and delivers the result.
    a_fetch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |=> (r_state == ST_IDLE) && o_valid)
        else $error("fetch did not complete in one cycle");

    // A command other than a pop produces its result in the next cycle, with busy low.
    a_direct_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.func != FUNC_POP_FRONT)
            && (i_cmd.func != FUNC_POP_BACK)) |=> o_valid && !busy)
        else $error("missing result for a single-cycle command");

endmodule

`default_nettype wire
